/* hdl/sdl_pkg.sv */
// shared types and constants for the sorted deque list
package sdl_pkg;

	localparam int CAPACITY   = 16;
	localparam int VALUE_BITS = 32;
	localparam int COUNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W      = $clog2(CAPACITY);

	typedef logic [VALUE_BITS-1:0] entry_t;
	typedef logic [COUNT_W-1:0]    count_t;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_INSERT     = 3'd4,
		OP_REMOVE     = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	// per-cell move controls
	typedef struct packed {
		logic load;
		logic take_left;
		logic take_right;
	} cell_ctl_t;

endpackage

/* hdl/sdl_cell.sv */
// one list slot: holds an entry, compares it to the key, moves to a neighbor
module sdl_cell import sdl_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  entry_t    key,
	input  entry_t    left_value,
	input  entry_t    right_value,
	output entry_t    value,
	output logic      lt,
	output logic      eq
);

	entry_t value_q;

	// local compare against the request key
	assign lt    = value_q < key;
	assign eq    = value_q == key;
	assign value = value_q;

	// load a new key or take a neighbor's entry
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			value_q <= key;
		end else if (ctl.take_left) begin
			value_q <= left_value;
		end else if (ctl.take_right) begin
			value_q <= right_value;
		end
	end

endmodule

/* hdl/sdl_ctrl.sv */
// operation decode: finds the place in the chain and steers every cell
module sdl_ctrl import sdl_pkg::*; (
	input  op_t                   op,
	input  count_t                count,
	input  logic [CAPACITY-1:0]   lt,
	input  logic [CAPACITY-1:0]   eq,
	output cell_ctl_t             ctl [CAPACITY],
	output count_t                next_count,
	output status_t               status
);

	logic [CAPACITY-1:0] occupied;
	count_t              ins_pos;
	count_t              rem_pos;
	logic                rem_hit;
	count_t              pos;
	logic                place;
	logic                drop;
	logic                full;
	logic                empty;

	assign full  = count == count_t'(CAPACITY);
	assign empty = count == '0;

	// first slot not below the key, and first slot equal to it
	always_comb begin
		ins_pos = count;
		rem_pos = '0;
		rem_hit = 1'b0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			occupied[i] = count_t'(i) < count;
			if (occupied[i] && !lt[i]) begin
				ins_pos = count_t'(i);
			end
			if (occupied[i] && eq[i]) begin
				rem_pos = count_t'(i);
				rem_hit = 1'b1;
			end
		end
	end

	// operation decode
	always_comb begin
		pos        = '0;
		place      = 1'b0;
		drop       = 1'b0;
		next_count = count;
		status     = ST_DONE;
		unique case (op) inside
			OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					place      = 1'b1;
					next_count = count + count_t'(1);
					if (op == OP_PUSH_FRONT) begin
						pos = '0;
					end else if (op == OP_PUSH_BACK) begin
						pos = count;
					end else begin
						pos = ins_pos;
					end
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					drop       = 1'b1;
					pos        = '0;
					next_count = count - count_t'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					next_count = count - count_t'(1);
				end
			end
			OP_REMOVE: begin
				if (rem_hit) begin
					drop       = 1'b1;
					pos        = rem_pos;
					next_count = count - count_t'(1);
				end else begin
					status = ST_MISSING;
				end
			end
			default: begin
				status = ST_DONE;
			end
		endcase
	end

	// per-cell steering: open a gap at pos or close the one there
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			ctl[i].load       = place && (count_t'(i) == pos);
			ctl[i].take_left  = place && (count_t'(i) > pos);
			ctl[i].take_right = drop && (count_t'(i) >= pos);
		end
	end

endmodule

/* hdl/sorted_deque_list.sv */
// top level: bounded ordered list built as a chain of entry cells
//
// A request (operation, value) is taken at a rising edge with start high and
// busy low. busy stays low: the chain takes a new request every cycle. Each
// request gives one result on the cycle after it is taken, marked by done for
// exactly that cycle: status, front_value, back_value, entry_count, is_empty.
// Throughput is one request per cycle; it rests on the compare in every cell
// followed by the position search and the shift of the whole chain, all
// combinational ahead of the registers.
// Operations: push front, push back, pop front, pop back, sorted insert and
// remove value; a push or insert on a full list, a pop on an empty one or a
// remove of a missing value leaves the list unchanged and is flagged.
// Reset (arst_n low) empties the list and clears done; entries need no
// clearing since slots beyond the count are never shown.
// The receiver cannot stall: each result is valid only in its done cycle and
// the ports move on with the next request.
module sorted_deque_list import sdl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [31:0] value,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] front_value,
	output logic [31:0] back_value,
	output logic [4:0]  entry_count,
	output logic        is_empty
);

	entry_t              key;
	entry_t              cell_value [CAPACITY];
	logic [CAPACITY-1:0] cell_lt;
	logic [CAPACITY-1:0] cell_eq;
	cell_ctl_t           dec_ctl    [CAPACITY];
	cell_ctl_t           cell_ctl   [CAPACITY];
	count_t              next_count;
	status_t             next_status;
	count_t              count_q;
	status_t             status_q;
	logic                done_q;
	logic                accept;
	count_t              last_idx;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign key    = value[VALUE_BITS-1:0];

	// decode
	sdl_ctrl u_ctrl (
		.op         (op_t'(operation)),
		.count      (count_q),
		.lt         (cell_lt),
		.eq         (cell_eq),
		.ctl        (dec_ctl),
		.next_count (next_count),
		.status     (next_status)
	);

	// chain of cells, front at index 0
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		entry_t left_v;
		entry_t right_v;
		if (g == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = cell_value[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_mid_r
			assign right_v = cell_value[g+1];
		end
		assign cell_ctl[g] = accept ? dec_ctl[g] : cell_ctl_t'('0);
		sdl_cell u_cell (
			.clk         (clk),
			.ctl         (cell_ctl[g]),
			.key         (key),
			.left_value  (left_v),
			.right_value (right_v),
			.value       (cell_value[g]),
			.lt          (cell_lt[g]),
			.eq          (cell_eq[g])
		);
	end

	// count, status and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= ST_DONE;
			done_q   <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q  <= next_count;
				status_q <= next_status;
			end
		end
	end

	// result ports
	assign last_idx    = count_q - count_t'(1);
	assign done        = done_q;
	assign status      = status_q;
	assign entry_count = count_q;
	assign is_empty    = count_q == '0;
	assign front_value = is_empty ? '0 : cell_value[0];
	assign back_value  = is_empty ? '0 : cell_value[last_idx[POS_W-1:0]];

`ifndef NO_ASSERTIONS
	// the count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= count_t'(CAPACITY))
		else $error("entry count above capacity");

	// every taken request gives exactly one result in the next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("request without result");

	// a flagged request leaves the count unchanged
	a_flag_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && next_status != ST_DONE |=> count_q == $past(count_q))
		else $error("flagged request changed the list");

	// full flag only with a full list
	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done && status_q == ST_FULL |-> count_q == count_t'(CAPACITY))
		else $error("full status without full list");
`endif

endmodule
